/* rtl/pbfa_pkg.sv */
// Package with the sizes, codes and sequencer states of the packed bit-field array.
package pbfa_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int POS_W       = ADDR_W + 3;

	localparam int FUNC_W     = 2;
	localparam int INDEX_W    = 13;
	localparam int DATA_W     = 32;
	localparam int WIDTH_W    = 6;
	localparam int COUNT_W    = 14;
	localparam int PROD_W     = COUNT_W + WIDTH_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam int WIN_BYTES = 5;
	localparam int WIN_W     = WIN_BYTES * 8;
	localparam int NB_W      = 3;

	localparam logic [PROD_W:0] STORE_BITS = (PROD_W + 1)'(STORE_BYTES * 8);

	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MULT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'd1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DECIDE,
		ST_READ,
		ST_EXTRACT,
		ST_MUL,
		ST_MERGE,
		ST_WRITE,
		ST_RESP
	} state_t;

endpackage

/* rtl/packed_bit_field_array.sv */
// Packed bit-field array: byte store, element sequencer and shared multiplier.
// An element touching n store bytes (n = 1..5) is fetched byte by byte from the store.
// Writes store it back bytewise, as multiply-all does for each covered element in turn.
// A request is taken only once the previous result is in the free output register.
// After reset all 1024 store bytes are cleared one by one while no request is taken.
// Configuration writes are taken in every cycle and the registers reset to width 8, count 0.
module packed_bit_field_array (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pbfa_pkg::FUNC_W-1:0]      func,
	input  logic [pbfa_pkg::INDEX_W-1:0]     elem_index,
	input  logic [pbfa_pkg::DATA_W-1:0]      operand,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pbfa_pkg::DATA_W-1:0]      read_value,
	output logic                             range_error,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pbfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pbfa_pkg::*;

	state_t state_q, state_d;

	logic [WIDTH_W-1:0] element_width_q;
	logic [COUNT_W-1:0] element_count_q;
	logic [WIDTH_W-1:0] w;

	logic [FUNC_W-1:0]  func_q;
	logic [INDEX_W-1:0] idx_q;
	logic [DATA_W-1:0]  opnd_q;
	logic [PROD_W-1:0]  prod_q;
	logic [POS_W-1:0]   pos_q;
	logic [COUNT_W-1:0] elem_q;
	logic [NB_W-1:0]    k_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [WIN_W-1:0]   win_q;
	logic [DATA_W-1:0]  val_q;
	logic [DATA_W-1:0]  mprod_q;
	logic [DATA_W-1:0]  res_val_q;
	logic               res_err_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_val_q;
	logic               out_err_q;

	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        mem_rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_wdata;

	logic [COUNT_W-1:0] mul_a;
	logic [ADDR_W-1:0]  base_addr;
	logic [NB_W-1:0]    nb;
	logic [NB_W-1:0]    k_m1;
	logic [DATA_W-1:0]  mask;
	logic [WIN_W-1:0]   shifted;
	logic [DATA_W-1:0]  ext;
	logic [DATA_W-1:0]  new_val;
	logic [WIN_W-1:0]   mask_win;
	logic [WIN_W-1:0]   val_win;
	logic               skip;
	logic               last_elem;

	assign w         = (element_width_q > WIDTH_W'(DATA_W)) ? WIDTH_W'(DATA_W) : element_width_q;
	assign mul_a     = (func_q == FUNC_MULT) ? element_count_q : (COUNT_W'(idx_q) + COUNT_W'(1));
	assign base_addr = pos_q[POS_W-1:3];
	assign nb        = NB_W'((7'(pos_q[2:0]) + 7'(w) + 7'd7) >> 3);
	assign k_m1      = k_q - NB_W'(1);
	assign mask      = (w == WIDTH_W'(DATA_W)) ? '1 : ((DATA_W'(1) << w) - DATA_W'(1));
	assign shifted   = win_q >> pos_q[2:0];
	assign ext       = shifted[DATA_W-1:0] & mask;
	assign new_val   = ((func_q == FUNC_MULT) ? mprod_q : opnd_q) & mask;
	assign mask_win  = WIN_W'(mask) << pos_q[2:0];
	assign val_win   = WIN_W'(new_val) << pos_q[2:0];
	assign skip      = (func_q == FUNC_MULT) ? (w == '0 || element_count_q == '0)
	                                         : (func_q != FUNC_READ && func_q != FUNC_WRITE) ||
	                                           (w == '0);
	assign last_elem = (elem_q + COUNT_W'(1)) == element_count_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign read_value  = out_val_q;
	assign range_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = base_addr + ADDR_W'(k_q);
		mem_wdata = win_q[{k_q, 3'b000} +: 8];
		mem_raddr = base_addr + ADDR_W'(k_q);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (skip || {1'b0, prod_q} > STORE_BITS) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (k_q == nb) begin
					state_d = ST_EXTRACT;
				end
			end
			ST_EXTRACT: begin
				case (func_q)
					FUNC_READ: state_d = ST_RESP;
					FUNC_MULT: state_d = ST_MUL;
					default:   state_d = ST_MERGE;
				endcase
			end
			ST_MUL: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				if (k_q == nb - NB_W'(1)) begin
					if (func_q == FUNC_MULT && !last_elem) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_width_q <= WIDTH_W'(8);
			element_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ELEMENT_WIDTH: element_width_q <= cfg_data[WIDTH_W-1:0];
				CFG_ELEMENT_COUNT: element_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			k_q         <= '0;
			elem_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			case (state_q)
				ST_DECIDE: begin
					k_q    <= '0;
					elem_q <= '0;
				end
				ST_READ: begin
					k_q <= (k_q == nb) ? '0 : k_q + NB_W'(1);
				end
				ST_WRITE: begin
					if (k_q == nb - NB_W'(1)) begin
						k_q    <= '0;
						elem_q <= elem_q + COUNT_W'(1);
					end else begin
						k_q <= k_q + NB_W'(1);
					end
				end
				default: ;
			endcase
			if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q    <= func;
				idx_q     <= elem_index;
				opnd_q    <= operand;
				res_val_q <= '0;
				res_err_q <= 1'b0;
			end
			ST_CHECK: begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(w);
			end
			ST_DECIDE: begin
				res_err_q <= !skip && ({1'b0, prod_q} > STORE_BITS);
				pos_q     <= (func_q == FUNC_MULT) ? '0 : POS_W'(prod_q - PROD_W'(w));
			end
			ST_READ: begin
				if (k_q != '0) begin
					win_q[{k_m1, 3'b000} +: 8] <= mem_rdata_q;
				end
			end
			ST_EXTRACT: begin
				val_q <= ext;
				if (func_q == FUNC_READ) begin
					res_val_q <= ext;
				end
			end
			ST_MUL: begin
				mprod_q <= val_q * opnd_q;
			end
			ST_MERGE: begin
				win_q <= (win_q & ~mask_win) | val_win;
			end
			ST_WRITE: begin
				if (k_q == nb - NB_W'(1)) begin
					pos_q <= pos_q + POS_W'(w);
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_val_q <= res_val_q;
					out_err_q <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_WRITE || state_q == ST_CLEAR))
		else $error("store written outside a write or clear state");

	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (k_q <= nb && nb >= NB_W'(1) && nb <= NB_W'(WIN_BYTES)))
		else $error("byte counter out of range during element read");

	a_error_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_err_q && out_val_q != '0))
		else $error("range error reported with a nonzero value");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in work");

endmodule

/* sim/tb.sv */
// Self-checking testbench for the packed bit-field array: random reads, writes and multiply-all.
`timescale 1ns / 1ps

module tb;
	import pbfa_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  operand;
		bit                 drain;
	} request_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              err;
	} outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func;
	logic [INDEX_W-1:0]    elem_index;
	logic [DATA_W-1:0]     operand;
	logic                  out_valid;
	logic                  out_ready;
	logic [DATA_W-1:0]     read_value;
	logic                  range_error;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	packed_bit_field_array uut (.*);

	bit [7:0]           shadow_store [STORE_BYTES];
	logic [WIDTH_W-1:0] shadow_width = 6'd8;
	logic [COUNT_W-1:0] shadow_count = '0;

	request_t request_q [$];
	outcome_t result_q [$];

	request_t    send_item;
	bit          send_loaded;
	bit          send_calm;
	int unsigned send_gap;
	bit          req_taken;
	bit          recv_calm;
	int unsigned recv_stall;
	bit          result_taken;

	int unsigned n_fail;
	int unsigned n_reads, n_writes, n_mults, n_spare, n_range, n_cfg;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [DATA_W-1:0] elem_get(int unsigned idx, int unsigned w);
		logic [DATA_W-1:0] v;
		int unsigned b, p;
		v = '0;
		for (b = 0; b < w; b++) begin
			p = idx * w + b;
			v[b] = shadow_store[p / 8][p % 8];
		end
		return v;
	endfunction

	function automatic void elem_put(int unsigned idx, int unsigned w, logic [DATA_W-1:0] v);
		int unsigned b, p;
		for (b = 0; b < w; b++) begin
			p = idx * w + b;
			shadow_store[p / 8][p % 8] = v[b];
		end
	endfunction

	function automatic outcome_t apply_request(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
			logic [DATA_W-1:0] op);
		outcome_t r;
		int unsigned w, i;
		longint unsigned bits;
		r = '0;
		w = (shadow_width > 6'd32) ? 32 : shadow_width;
		bits = STORE_BYTES * 8;
		if ((f == FUNC_READ || f == FUNC_WRITE) && w != 0) begin
			if ((longint'(idx) + 1) * w > bits)
				r.err = 1'b1;
			else if (f == FUNC_READ)
				r.value = elem_get(idx, w);
			else
				elem_put(idx, w, op);
		end else if (f == FUNC_MULT && w != 0 && shadow_count != 0) begin
			if (longint'(shadow_count) * w > bits)
				r.err = 1'b1;
			else
				for (i = 0; i < shadow_count; i++)
					elem_put(i, w, elem_get(i, w) * op);
		end
		return r;
	endfunction

	function automatic void push_request(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
			logic [DATA_W-1:0] op, bit drain);
		request_t q;
		q.func = f;
		q.index = idx;
		q.operand = op;
		q.drain = drain;
		request_q.push_back(q);
	endfunction

	// Request side: each request waits a drawn number of cycles before valid rises.
	// A request marked drain also waits until every expected result has come back.
	always @(negedge clk) begin
		logic drive;
		if (arst_n) begin
			drive = in_valid;
			if (req_taken) begin
				req_taken = 1'b0;
				drive = 1'b0;
			end
			if (!drive) begin
				if (!send_loaded && request_q.size() != 0) begin
					send_item = request_q.pop_front();
					if ($urandom_range(0, 39) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : $urandom_range(0, 18);
					send_loaded = 1'b1;
				end
				if (send_loaded) begin
					if (send_gap != 0) begin
						send_gap--;
					end else if (!(send_item.drain && result_q.size() != 0)) begin
						drive = 1'b1;
						func <= send_item.func;
						elem_index <= send_item.index;
						operand <= send_item.operand;
						send_loaded = 1'b0;
					end
				end
			end
			in_valid <= drive;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				result_taken = 1'b0;
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_stall = recv_calm ? 0 : $urandom_range(0, 18);
			end
			if (out_valid && recv_stall != 0)
				recv_stall--;
			out_ready <= (recv_stall == 0);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				n_cfg++;
				case (cfg_index)
					CFG_ELEMENT_WIDTH: shadow_width = cfg_data[WIDTH_W-1:0];
					CFG_ELEMENT_COUNT: shadow_count = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = apply_request(func, elem_index, operand);
				result_q.push_back(want);
				req_taken = 1'b1;
				case (func)
					FUNC_READ:  n_reads++;
					FUNC_WRITE: n_writes++;
					FUNC_MULT:  n_mults++;
					default:    n_spare++;
				endcase
				if (want.err)
					n_range++;
			end
			if (out_valid && out_ready) begin
				result_taken = 1'b1;
				if (result_q.size() == 0) begin
					$error("result arrived with no request outstanding");
					n_fail++;
				end else begin
					want = result_q.pop_front();
					if (read_value !== want.value) begin
						$error("read_value: expected %h, got %h", want.value, read_value);
						n_fail++;
					end
					if (range_error !== want.err) begin
						$error("range_error: expected %b, got %b", want.err, range_error);
						n_fail++;
					end
				end
			end
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (request_q.size() != 0 || send_loaded || in_valid || result_q.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [WIDTH_W-1:0] w, logic [COUNT_W-1:0] count, int n);
		int unsigned eff, last, hot, r, idx, k;
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] op;
		write_reg(CFG_ELEMENT_WIDTH, {8'($urandom_range(0, 255)), w});
		write_reg(CFG_ELEMENT_COUNT, count);
		eff = (w > 6'd32) ? 32 : w;
		last = (eff == 0) ? 8191 : 8192 / eff - 1;
		hot = (count != 0) ? count + 4 : 20;
		if (hot > last)
			hot = last;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 44)
				f = FUNC_READ;
			else if (r < 88)
				f = FUNC_WRITE;
			else if (r < 95)
				f = FUNC_MULT;
			else
				f = FUNC_SPARE;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: idx = $urandom_range(0, hot);
				5, 6:          idx = $urandom_range(0, last);
				7, 8:          idx = $urandom_range(last - 1, (last + 2 > 8191) ? 8191 : last + 2);
				default:       idx = $urandom_range(0, 8191);
			endcase
			case ($urandom_range(0, 9))
				6:       op = '0;
				7:       op = 32'd1;
				8:       op = '1;
				9:       op = $urandom_range(0, 15);
				default: op = $urandom();
			endcase
			push_request(f, INDEX_W'(idx), op, $urandom_range(0, 99) == 0);
		end
		wait_idle();
	endtask

	initial begin
		int unsigned w;
		in_valid = 1'b0;
		func = FUNC_READ;
		elem_index = '0;
		operand = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ELEMENT_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: byte-wide elements and an empty multiply-all range.
		push_request(FUNC_WRITE, 13'd0, 32'hFFFF_FFFF, 1'b0);
		push_request(FUNC_READ, 13'd0, 32'h0, 1'b0);
		push_request(FUNC_WRITE, 13'd1023, 32'h1234_56A5, 1'b0);
		push_request(FUNC_READ, 13'd1023, 32'h0, 1'b0);
		push_request(FUNC_READ, 13'd1024, 32'h0, 1'b0);
		push_request(FUNC_WRITE, 13'd8191, 32'hFFFF_FFFF, 1'b0);
		push_request(FUNC_MULT, 13'd0, 32'd2, 1'b0);
		push_request(FUNC_SPARE, 13'd8191, 32'hFFFF_FFFF, 1'b0);
		wait_idle();

		write_reg(CFG_ELEMENT_WIDTH, 14'd32);
		write_reg(CFG_ELEMENT_COUNT, 14'd3);
		push_request(FUNC_WRITE, 13'd0, 32'hFFFF_FFFF, 1'b0);
		push_request(FUNC_WRITE, 13'd1, 32'h8000_0001, 1'b0);
		push_request(FUNC_WRITE, 13'd2, 32'd7, 1'b0);
		push_request(FUNC_MULT, 13'd0, 32'hFFFF_FFFF, 1'b0);
		push_request(FUNC_READ, 13'd0, 32'h0, 1'b0);
		push_request(FUNC_READ, 13'd1, 32'h0, 1'b0);
		push_request(FUNC_READ, 13'd2, 32'h0, 1'b0);
		push_request(FUNC_WRITE, 13'd255, 32'hDEAD_BEEF, 1'b0);
		push_request(FUNC_READ, 13'd256, 32'h0, 1'b0);
		wait_idle();

		// Zero-bit elements do nothing and never flag an error.
		write_reg(CFG_ELEMENT_WIDTH, 14'd0);
		write_reg(CFG_ELEMENT_COUNT, 14'd5);
		push_request(FUNC_READ, 13'd3, 32'h0, 1'b0);
		push_request(FUNC_WRITE, 13'd3, 32'hFFFF, 1'b0);
		push_request(FUNC_MULT, 13'd0, 32'd5, 1'b0);
		wait_idle();

		// Oversized width acts as 32 bits; the largest count overruns the store.
		write_reg(CFG_ELEMENT_WIDTH, 14'h3FFF);
		write_reg(CFG_ELEMENT_COUNT, 14'h3FFF);
		push_request(FUNC_READ, 13'd255, 32'h0, 1'b0);
		push_request(FUNC_MULT, 13'd0, 32'd3, 1'b0);
		wait_idle();

		// Single-bit elements with a multiply-all covering the whole store.
		write_reg(CFG_ELEMENT_WIDTH, 14'd1);
		write_reg(CFG_ELEMENT_COUNT, 14'd8192);
		push_request(FUNC_WRITE, 13'd8191, 32'd1, 1'b0);
		push_request(FUNC_MULT, 13'd0, 32'd3, 1'b0);
		push_request(FUNC_READ, 13'd8191, 32'h0, 1'b0);
		wait_idle();

		run_phase(6'd1, 14'($urandom_range(1, 48)), 240);
		run_phase(6'd32, 14'd256, 240);
		w = $urandom_range(2, 12);
		run_phase(6'(w), 14'($urandom_range(8192 / w + 1, 16383)), 240);
		run_phase(6'd13, 14'($urandom_range(1, 48)), 240);
		run_phase(6'd63, 14'($urandom_range(1, 48)), 240);
		w = $urandom_range(17, 31);
		run_phase(6'(w), 14'(8192 / w), 240);
		run_phase(6'($urandom_range(2, 12)), 14'd0, 240);
		run_phase(6'($urandom_range(1, 32)), 14'($urandom_range(1, 48)), 240);

		if (result_q.size() != 0) begin
			$error("%0d expected results never arrived", result_q.size());
			n_fail++;
		end
		$display("Run covered %0d reads, %0d writes, %0d multiply-all and %0d unused-code requests.",
			n_reads, n_writes, n_mults, n_spare);
		$display("%0d requests ran past the store end; %0d register writes set the shape.",
			n_range, n_cfg);
		if (n_fail == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
